### hdl/scwrq_pkg.sv
package scwrq_pkg;

  // FIFO sizing
  localparam int CODE_DEPTH   = 16;
  localparam int WAITER_DEPTH = 16;
  localparam int ID_WIDTH     = 16;

  // Fixed field widths
  localparam int CODE_W = 8;
  localparam int REQ_W  = 16;
  localparam int STAT_W = 3;

  // Stored id width: the id is masked to ID_WIDTH and never exceeds the port
  localparam int SID_W = (ID_WIDTH < REQ_W) ? ID_WIDTH : REQ_W;

  localparam int CODE_AW = $clog2(CODE_DEPTH);
  localparam int CODE_CW = $clog2(CODE_DEPTH + 1);
  localparam int WAIT_AW = $clog2(WAITER_DEPTH);
  localparam int WAIT_CW = $clog2(WAITER_DEPTH + 1);

  localparam logic [CODE_AW-1:0] CODE_LAST = CODE_AW'(CODE_DEPTH - 1);
  localparam logic [CODE_CW-1:0] CODE_FULL = CODE_CW'(CODE_DEPTH);
  localparam logic [WAIT_AW-1:0] WAIT_LAST = WAIT_AW'(WAITER_DEPTH - 1);
  localparam logic [WAIT_CW-1:0] WAIT_FULL = WAIT_CW'(WAITER_DEPTH);

  typedef enum logic {
    OP_SCANCODE = 1'b0,
    OP_READ     = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DELIVERED      = 3'd0,
    ST_CODE_BUFFERED  = 3'd1,
    ST_WAITER_QUEUED  = 3'd2,
    ST_CODE_DROPPED   = 3'd3,
    ST_WAITER_DROPPED = 3'd4
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the request, launch the head reads
    logic commit;   // update the FIFOs, load the result register
  } dp_cmd_t;

endpackage

### hdl/scwrq_ram.sv
module scwrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/scwrq_ctrl.sv
module scwrq_ctrl import scwrq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold while the result register is still occupied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hdl/scwrq_dp.sv
module scwrq_dp import scwrq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic              op_i,
  input  logic [CODE_W-1:0] scancode_i,
  input  logic [REQ_W-1:0]  requester_id_i,
  output logic              reply_valid_o,
  output logic [REQ_W-1:0]  reply_to_o,
  output logic [CODE_W-1:0] reply_code_o,
  output logic [STAT_W-1:0] status_o
);

  // Latched request
  op_e               op_q;
  logic [CODE_W-1:0] code_q;
  logic [SID_W-1:0]  id_q;

  // FIFO pointers and fill levels
  logic [CODE_AW-1:0] c_head_q, c_head_d, c_tail_q, c_tail_d;
  logic [CODE_CW-1:0] c_cnt_q, c_cnt_d;
  logic [WAIT_AW-1:0] w_head_q, w_head_d, w_tail_q, w_tail_d;
  logic [WAIT_CW-1:0] w_cnt_q, w_cnt_d;

  logic              c_we, w_we;
  logic [CODE_W-1:0] c_rdata;
  logic [SID_W-1:0]  w_rdata;

  // Result register
  logic              rv_q, rv_d;
  logic [REQ_W-1:0]  rto_q, rto_d;
  logic [CODE_W-1:0] rcode_q, rcode_d;
  status_e           st_q, st_d;

  scwrq_ram #(.WIDTH(CODE_W), .DEPTH(CODE_DEPTH)) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_tail_q),
    .wdata_i (code_q),
    .re_i    (cmd_i.capture),
    .raddr_i (c_head_q),
    .rdata_o (c_rdata)
  );

  scwrq_ram #(.WIDTH(SID_W), .DEPTH(WAITER_DEPTH)) u_waiter_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_tail_q),
    .wdata_i (id_q),
    .re_i    (cmd_i.capture),
    .raddr_i (w_head_q),
    .rdata_o (w_rdata)
  );

  always_comb begin
    c_head_d = c_head_q;
    c_tail_d = c_tail_q;
    c_cnt_d  = c_cnt_q;
    w_head_d = w_head_q;
    w_tail_d = w_tail_q;
    w_cnt_d  = w_cnt_q;
    c_we     = 1'b0;
    w_we     = 1'b0;
    rv_d     = 1'b0;
    rto_d    = '0;
    rcode_d  = '0;
    st_d     = ST_DELIVERED;
    case (op_q)
      OP_SCANCODE: begin
        if (w_cnt_q != '0) begin
          rv_d     = 1'b1;
          rto_d    = REQ_W'(w_rdata);
          rcode_d  = code_q;
          w_head_d = (w_head_q == WAIT_LAST) ? '0 : w_head_q + WAIT_AW'(1);
          w_cnt_d  = w_cnt_q - WAIT_CW'(1);
        end else if (c_cnt_q == CODE_FULL) begin
          st_d = ST_CODE_DROPPED;
        end else begin
          st_d     = ST_CODE_BUFFERED;
          c_we     = cmd_i.commit;
          c_tail_d = (c_tail_q == CODE_LAST) ? '0 : c_tail_q + CODE_AW'(1);
          c_cnt_d  = c_cnt_q + CODE_CW'(1);
        end
      end
      default: begin
        if (c_cnt_q != '0) begin
          rv_d     = 1'b1;
          rto_d    = REQ_W'(id_q);
          rcode_d  = c_rdata;
          c_head_d = (c_head_q == CODE_LAST) ? '0 : c_head_q + CODE_AW'(1);
          c_cnt_d  = c_cnt_q - CODE_CW'(1);
        end else if (w_cnt_q == WAIT_FULL) begin
          st_d = ST_WAITER_DROPPED;
        end else begin
          st_d     = ST_WAITER_QUEUED;
          w_we     = cmd_i.commit;
          w_tail_d = (w_tail_q == WAIT_LAST) ? '0 : w_tail_q + WAIT_AW'(1);
          w_cnt_d  = w_cnt_q + WAIT_CW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_head_q <= '0;
      c_tail_q <= '0;
      c_cnt_q  <= '0;
      w_head_q <= '0;
      w_tail_q <= '0;
      w_cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      c_head_q <= c_head_d;
      c_tail_q <= c_tail_d;
      c_cnt_q  <= c_cnt_d;
      w_head_q <= w_head_d;
      w_tail_q <= w_tail_d;
      w_cnt_q  <= w_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(op_i);
      code_q <= scancode_i;
      id_q   <= requester_id_i[SID_W-1:0];
    end
    if (cmd_i.commit) begin
      rv_q    <= rv_d;
      rto_q   <= rto_d;
      rcode_q <= rcode_d;
      st_q    <= st_d;
    end
  end

  assign reply_valid_o = rv_q;
  assign reply_to_o    = rto_q;
  assign reply_code_o  = rcode_q;
  assign status_o      = st_q;

endmodule

### hdl/scancode_waiter_rendezvous_queue.sv
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_ready_o  op_i, scancode_i, requester_id_i
// result    out        out_valid_o/ out_ready_i reply_valid_o, reply_to_o,
//                                               reply_code_o, status_o
//
// Each request is handled in a capture step and a commit step. Capture latches it
// and reads both FIFO heads from the registered RAMs; commit, once the output
// register is free, updates the FIFOs and loads the result. One request is in
// flight at a time. A result waiting in the output register does not block
// acceptance; only the update step waits for the output register to drain.
// Reset clears pointers, fill levels and the output valid flag; FIFO storage is left
// undefined and is only read where the fill level counts it.
module scancode_waiter_rendezvous_queue import scwrq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [CODE_W-1:0] scancode_i,
  input  logic [REQ_W-1:0]  requester_id_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              reply_valid_o,
  output logic [REQ_W-1:0]  reply_to_o,
  output logic [CODE_W-1:0] reply_code_o,
  output logic [STAT_W-1:0] status_o
);

  // Commands from the sequencer into the FIFO datapath
  dp_cmd_t cmd;

  // Sequence each request: capture, then commit once the result slot is free
  scwrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Hold both FIFOs, pair a scancode with the oldest waiter or vice versa
  scwrq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .scancode_i     (scancode_i),
    .requester_id_i (requester_id_i),
    .reply_valid_o  (reply_valid_o),
    .reply_to_o     (reply_to_o),
    .reply_code_o   (reply_code_o),
    .status_o       (status_o)
  );

endmodule

### hdl/scwrq_checker.sv
module scwrq_checker import scwrq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              op_i,
  input logic [CODE_W-1:0] scancode_i,
  input logic [REQ_W-1:0]  requester_id_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              reply_valid_o,
  input logic [REQ_W-1:0]  reply_to_o,
  input logic [CODE_W-1:0] reply_code_o,
  input logic [STAT_W-1:0] status_o
);

  // One request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(reply_valid_o)
      && $stable(reply_to_o) && $stable(reply_code_o) && $stable(status_o)))
    else $error("stalled result changed");

  // A reply goes out exactly when the status says delivered
  a_reply_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reply_valid_o == (status_o == ST_DELIVERED)))
    else $error("reply flag and status disagree");

  // A result without a reply carries zero id and code
  a_no_reply_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !reply_valid_o) |-> (reply_to_o == '0 && reply_code_o == '0))
    else $error("non-reply result carries payload");

  // Status is a legal code
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_WAITER_DROPPED))
    else $error("status out of range");

endmodule

bind scancode_waiter_rendezvous_queue scwrq_checker u_scwrq_checker (.*);

### verif/scwrq_reply_checker.sv
`timescale 1ns / 100ps

module scwrq_reply_checker import scwrq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              op_i,
  input  logic [CODE_W-1:0] scancode_i,
  input  logic [REQ_W-1:0]  requester_id_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              reply_valid_i,
  input  logic [REQ_W-1:0]  reply_to_i,
  input  logic [CODE_W-1:0] reply_code_i,
  input  logic [STAT_W-1:0] status_i,
  output int                fail_count_o,
  output int                replies_due_o
);

  localparam int MAX_PRINTED = 200;

  typedef struct packed {
    logic              reply_valid;
    logic [REQ_W-1:0]  reply_to;
    logic [CODE_W-1:0] reply_code;
    status_e           status;
  } reply_t;

  logic [CODE_W-1:0] held_codes[$];
  logic [SID_W-1:0]  parked_readers[$];
  reply_t            due_replies[$];
  int                mismatch_count;
  int                due_count;

  assign fail_count_o  = mismatch_count;
  assign replies_due_o = due_count;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Pair a scancode with the oldest parked reader or a read with the oldest held code, or park
  // whichever side has no partner; drop it when its queue is full.
  function automatic reply_t rendezvous(input logic op, input logic [CODE_W-1:0] code,
                                        input logic [REQ_W-1:0] id);
    reply_t r;
    r.reply_valid = 1'b0;
    r.reply_to    = '0;
    r.reply_code  = '0;
    r.status      = ST_DELIVERED;
    if (op == OP_SCANCODE) begin
      if (parked_readers.size() != 0) begin
        r.reply_valid = 1'b1;
        r.reply_to    = REQ_W'(parked_readers.pop_front());
        r.reply_code  = code;
      end else if (held_codes.size() >= CODE_DEPTH) begin
        r.status = ST_CODE_DROPPED;
      end else begin
        held_codes.push_back(code);
        r.status = ST_CODE_BUFFERED;
      end
    end else begin
      if (held_codes.size() != 0) begin
        r.reply_valid = 1'b1;
        r.reply_to    = REQ_W'(id[SID_W-1:0]);
        r.reply_code  = held_codes.pop_front();
      end else if (parked_readers.size() >= WAITER_DEPTH) begin
        r.status = ST_WAITER_DROPPED;
      end else begin
        parked_readers.push_back(id[SID_W-1:0]);
        r.status = ST_WAITER_QUEUED;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    reply_t want;
    if (!rst_ni) begin
      held_codes.delete();
      parked_readers.delete();
      due_replies.delete();
      mismatch_count = 0;
      due_count      = 0;
    end else begin
      if (in_valid_i && in_ready_i)
        due_replies.push_back(rendezvous(op_i, scancode_i, requester_id_i));
      if (out_valid_i && out_ready_i) begin
        if (due_replies.size() == 0) begin
          report_mismatch("unexpected reply, status", 32'(status_i), 32'hffff_ffff);
        end else begin
          want = due_replies.pop_front();
          if (reply_valid_i !== want.reply_valid)
            report_mismatch("reply_valid", 32'(reply_valid_i), 32'(want.reply_valid));
          if (reply_to_i !== want.reply_to)
            report_mismatch("reply_to", 32'(reply_to_i), 32'(want.reply_to));
          if (reply_code_i !== want.reply_code)
            report_mismatch("reply_code", 32'(reply_code_i), 32'(want.reply_code));
          if (status_i !== want.status)
            report_mismatch("status", 32'(status_i), 32'(want.status));
        end
      end
      due_count = due_replies.size();
    end
  end

endmodule

### verif/tb_scancode_waiter_rendezvous_queue.sv
`timescale 1ns / 100ps

module tb_scancode_waiter_rendezvous_queue;
  import scwrq_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 9;
  localparam int RANDOM_REQUESTS = 1900;
  // Extra idle cycles at the end to catch stray results.
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  // Far beyond the slowest legal run: every request behind the longest
  // sender gap and the longest receiver stall.
  localparam int TIMEOUT_NS      = 15_000_000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              op_i;
  logic [CODE_W-1:0] scancode_i;
  logic [REQ_W-1:0]  requester_id_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              reply_valid_o;
  logic [REQ_W-1:0]  reply_to_o;
  logic [CODE_W-1:0] reply_code_o;
  logic [STAT_W-1:0] status_o;

  int fail_count;
  int replies_due;

  // Pacing knobs set by the stimulus; the sender reads feed_calm, the result sink sink_calm, both hold_off_req.
  bit feed_calm;
  bit sink_calm;
  bit hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  scancode_waiter_rendezvous_queue i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .scancode_i,
    .requester_id_i,
    .out_valid_o,
    .out_ready_i,
    .reply_valid_o,
    .reply_to_o,
    .reply_code_o,
    .status_o
  );

  scwrq_reply_checker i_reply_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i     (in_ready_o),
    .op_i,
    .scancode_i,
    .requester_id_i,
    .out_valid_i    (out_valid_o),
    .out_ready_i,
    .reply_valid_i  (reply_valid_o),
    .reply_to_i     (reply_to_o),
    .reply_code_i   (reply_code_o),
    .status_i       (status_o),
    .fail_count_o   (fail_count),
    .replies_due_o  (replies_due)
  );

  // Present one request and hold it until the block takes it. Call on a rising
  // edge; return on the edge that accepted the request.
  task automatic offer_request(input op_e op, input logic [CODE_W-1:0] code,
                               input logic [REQ_W-1:0] id);
    in_valid_i     <= 1'b1;
    op_i           <= op;
    scancode_i     <= code;
    requester_id_i <= id;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid for a while; a zero gap keeps valid high into the next request.
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Mostly back to back, sometimes a few cycles, rarely a long silence; none when calm or on hold-off.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (feed_calm || hold_off_req) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Stop offering and wait until every predicted reply has come out. Sample on
  // the falling edge so the checker's count is settled, then realign.
  task automatic settle_all_replies();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (replies_due != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Result sink: random backpressure, calm stretches, and one long hold-off
  // on request so the block fills up and stalls its input.
  initial begin : result_sink
    int r;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk_i);
      end else if (sink_calm) begin
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(15, 50) - 1) @(posedge clk_i);
        end else begin
          out_ready_i <= (r >= 25);
        end
      end
    end
  end

  initial begin : stimulus
    int   sent;
    int   seg;
    int   seg_len;
    int   read_pct;
    bit   calm;
    op_e  op;

    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    op_i           <= OP_SCANCODE;
    scancode_i     <= '0;
    requester_id_i <= '0;
    feed_calm      = 1'b0;
    sink_calm      = 1'b0;
    hold_off_req   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: readers park first, then scancodes meet them; then codes get
    // buffered and picked up. Extremes of the code and id ride along.
    offer_request(OP_READ,     8'h3c, 16'hffff);
    offer_request(OP_READ,     8'hff, 16'h0000);
    offer_request(OP_SCANCODE, 8'hff, 16'h1234);
    offer_request(OP_SCANCODE, 8'h00, 16'hffff);
    offer_request(OP_SCANCODE, 8'h00, 16'h0000);
    offer_request(OP_SCANCODE, 8'hff, 16'hffff);
    offer_request(OP_READ,     8'h00, 16'ha5a5);
    pause_sender(3);
    offer_request(OP_READ,     8'hff, 16'h5a5a);
    offer_request(OP_READ,     8'h55, 16'h8001);
    offer_request(OP_SCANCODE, 8'h81, 16'h0001);
    offer_request(OP_SCANCODE, 8'h7e, 16'h7ffe);
    offer_request(OP_READ,     8'haa, 16'h0000);
    // Pause the sender until every reply is out.
    settle_all_replies();

    // Random segments, each with its own read/scancode mix. The first three fill
    // the scancode queue past full, drain it and overfill the reader queue,
    // then hand the parked readers their codes.
    sent = 0;
    seg  = 0;
    while (sent < RANDOM_REQUESTS) begin
      case (seg)
        0: begin
          read_pct = 0;
          seg_len  = 20;
        end
        1: begin
          read_pct = 100;
          seg_len  = 40;
        end
        2: begin
          read_pct = 0;
          seg_len  = 24;
        end
        default: begin
          read_pct = $urandom_range(0, 6) * 100 / 6;
          seg_len  = $urandom_range(5, 60);
        end
      endcase
      calm      = (seg > 2) && ($urandom_range(0, 4) == 0);
      feed_calm = calm;
      sink_calm = calm;
      for (int k = 0; k < seg_len && sent < RANDOM_REQUESTS; k++) begin
        if (sent == 500 || sent == 1500) hold_off_req = 1'b1;
        if (sent == 1000) settle_all_replies();
        op = ($urandom_range(0, 99) < read_pct) ? OP_READ : OP_SCANCODE;
        offer_request(op, CODE_W'($urandom()), REQ_W'($urandom()));
        sent++;
        pause_sender(sender_gap());
      end
      seg++;
    end

    settle_all_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && replies_due == 0) begin
      $display("PASS scancode_waiter_rendezvous_queue");
    end else begin
      $display("FAIL scancode_waiter_rendezvous_queue");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL scancode_waiter_rendezvous_queue");
    $finish;
  end

endmodule
